// ===== hdl/lpm_pkg.sv =====
package lpm_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;

    localparam logic [31:0] FULL_MASK  = 32'hFFFF_FFFF;
    localparam logic [5:0]  MAX_PREFIX = 6'd32;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_CLEAR  = 2'd0;
    localparam t_cmd CMD_APPEND = 2'd1;
    localparam t_cmd CMD_LOOKUP = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_DONE = 2'd0;
    localparam t_status STATUS_FULL = 2'd1;
    localparam t_status STATUS_HIT  = 2'd2;
    localparam t_status STATUS_MISS = 2'd3;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] address;
        logic [5:0]  prefix_length;
        logic [7:0]  out_port;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [7:0]  match_port;
        logic [5:0]  match_length;
        logic [31:0] match_network;
    } t_out_word;

    // One stored route as it sits in the table memory.
    typedef struct packed {
        logic [31:0] network;
        logic [5:0]  length;
        logic [7:0]  port;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

// ===== hdl/lpm_ram.sv =====
module lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/longest_prefix_match_lookup.sv =====
// Channel   Valid     Ready     Word      Direction
// command   i_valid   o_ready   i_word    into the block
// result    o_valid   i_ready   o_word    out of the block
//
// A clear, an append, an unused command or a lookup on an empty table loads its
// result word at the accepting edge, so the word can leave in the next cycle.
// A lookup makes one masked compare per stored entry through the single registered
// read port, then loads its result word in ST_FINISH once the output register is free.
// Reset is synchronous and active low; it zeroes the fill count, state and flags.
// A stalled result closes the input; a finished scan waits for the output register.
module longest_prefix_match_lookup #(
    parameter int TABLE_DEPTH = lpm_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lpm_pkg::t_in_word i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output lpm_pkg::t_out_word o_word
);

    // Address width of the table, and a count width that can also hold the
    // depth itself so that a full table can be told apart.
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_COUNT = CW'(TABLE_DEPTH);

    lpm_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [31:0]        r_dest, n_dest;
    logic [AW-1:0]      r_issue_idx, n_issue_idx;
    logic               r_issuing, n_issuing;
    logic               r_data_ok, n_data_ok;
    logic               r_found, n_found;
    lpm_pkg::t_entry    r_best, n_best;
    logic               r_out_valid, n_out_valid;
    lpm_pkg::t_out_word r_out_word, n_out_word;

    logic               accept;
    logic               out_free;
    logic               ram_we;
    logic               ram_re;
    lpm_pkg::t_entry    wr_entry;
    lpm_pkg::t_entry    rd_entry;
    logic [31:0]        entry_mask;
    logic               entry_hit;

    // The table memory: one write port for appends, one registered read port
    // for the scan.
    lpm_ram #(
        .WIDTH ($bits(lpm_pkg::t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (r_issue_idx),
        .o_rdata (rd_entry)
    );

    // A prefix length above 32 is stored as 32.
    always_comb begin
        wr_entry.network = i_word.address;
        wr_entry.length  = (i_word.prefix_length > lpm_pkg::MAX_PREFIX) ?
                           lpm_pkg::MAX_PREFIX : i_word.prefix_length;
        wr_entry.port    = i_word.out_port;
    end

    // The shared compare unit. Shifting the all-ones word right by the length
    // and inverting gives a zero mask for /0 and a full mask for /32.
    assign entry_mask = ~(lpm_pkg::FULL_MASK >> rd_entry.length);
    assign entry_hit  = ((r_dest ^ rd_entry.network) & entry_mask) == 32'd0;

    // The output register is free when empty or when its word leaves now.
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == lpm_pkg::ST_IDLE) && out_free;
    assign accept   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpm_pkg::ST_IDLE;
            r_count     <= '0;
            r_issuing   <= 1'b0;
            r_data_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issuing   <= n_issuing;
            r_data_ok   <= n_data_ok;
            r_out_valid <= n_out_valid;
        end
        r_dest      <= n_dest;
        r_issue_idx <= n_issue_idx;
        r_found     <= n_found;
        r_best      <= n_best;
        r_out_word  <= n_out_word;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dest      = r_dest;
        n_issue_idx = r_issue_idx;
        n_issuing   = r_issuing;
        n_data_ok   = r_data_ok;
        n_found     = r_found;
        n_best      = r_best;
        n_out_valid = r_out_valid && !i_ready;
        n_out_word  = r_out_word;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        case (r_state)
            lpm_pkg::ST_IDLE: begin
                if (accept) begin
                    // Every command except a lookup on a filled table answers
                    // straight away with zero match fields.
                    n_out_valid = 1'b1;
                    n_out_word  = '0;
                    n_out_word.status = lpm_pkg::STATUS_DONE;
                    case (i_word.cmd)
                        lpm_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        lpm_pkg::CMD_APPEND: begin
                            if (r_count == DEPTH_COUNT) begin
                                n_out_word.status = lpm_pkg::STATUS_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        lpm_pkg::CMD_LOOKUP: begin
                            if (r_count == '0) begin
                                n_out_word.status = lpm_pkg::STATUS_MISS;
                            end else begin
                                n_out_valid = r_out_valid && !i_ready;
                                n_out_word  = r_out_word;
                                n_dest      = i_word.address;
                                n_found     = 1'b0;
                                n_issue_idx = '0;
                                n_issuing   = 1'b1;
                                n_data_ok   = 1'b0;
                                n_state     = lpm_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            n_out_word.status = lpm_pkg::STATUS_DONE;
                        end
                    endcase
                end
            end

            lpm_pkg::ST_SCAN: begin
                // Issue one read per cycle; its data is compared in the next cycle.
                ram_re    = r_issuing;
                n_data_ok = r_issuing;
                if (r_issuing) begin
                    if (CW'(r_issue_idx) == r_count - CW'(1)) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_issue_idx = r_issue_idx + AW'(1);
                    end
                end
                if (r_data_ok) begin
                    // A strictly longer prefix replaces the best so far, so the
                    // earliest entry wins a tie.
                    if (entry_hit && (!r_found || rd_entry.length > r_best.length)) begin
                        n_found = 1'b1;
                        n_best  = rd_entry;
                    end
                    if (!r_issuing) begin
                        n_state = lpm_pkg::ST_FINISH;
                    end
                end
            end

            lpm_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_found) begin
                        n_out_word.status        = lpm_pkg::STATUS_HIT;
                        n_out_word.match_port    = r_best.port;
                        n_out_word.match_length  = r_best.length;
                        n_out_word.match_network = r_best.network;
                    end else begin
                        n_out_word        = '0;
                        n_out_word.status = lpm_pkg::STATUS_MISS;
                    end
                    n_state = lpm_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = lpm_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

endmodule

// ===== hdl/lpm_checker.sv =====
module lpm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input lpm_pkg::t_in_word  i_word,
    input logic               o_valid,
    input logic               i_ready,
    input lpm_pkg::t_out_word o_word
);

    // Reset empties the output register.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid after reset");

    // A stalled result word holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word))
        else $error("stalled result word changed");

    // Only a hit carries match fields.
    a_no_hit_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.status != lpm_pkg::STATUS_HIT |->
            o_word.match_port == 8'd0 && o_word.match_length == 6'd0 &&
            o_word.match_network == 32'd0)
        else $error("match fields set on a result without a hit");

    // A hit never reports a prefix longer than 32.
    a_hit_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.status == lpm_pkg::STATUS_HIT |->
            o_word.match_length <= lpm_pkg::MAX_PREFIX)
        else $error("matched prefix length out of range");

    // A clear answers with a done word in the next cycle.
    a_clear_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_word.cmd == lpm_pkg::CMD_CLEAR |=>
            o_valid && o_word.status == lpm_pkg::STATUS_DONE)
        else $error("clear did not answer in the next cycle");

endmodule

bind longest_prefix_match_lookup lpm_checker u_lpm_checker (.*);
